/* rtl/periodic_substitution_key_table_top_defines.svh */
// Assertion macros shared by the key table RTL.
`ifndef PERIODIC_SUBSTITUTION_KEY_TABLE_TOP_DEFINES_SVH
`define PERIODIC_SUBSTITUTION_KEY_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PSKT_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PSKT_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pskt_pkg.sv */
package pskt_pkg;

    localparam int MAX_PERIOD = 32;
    localparam int LETTERS    = 26;
    localparam int DEPTH      = MAX_PERIOD * LETTERS;
    localparam int ADDR_W     = $clog2(DEPTH);

    localparam int REQ_W = 3;
    localparam int LET_W = 5;
    localparam int ROW_W = 5;
    localparam int PER_W = 6;
    localparam int ST_W  = 2;

    localparam logic [REQ_W-1:0] REQ_DECODE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SUBST    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNDO_ROW = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UNDO_ALL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REVERSE  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_PERIOD = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_ROW   = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [LET_W-1:0] cipher_letter;
        logic [LET_W-1:0] plain_letter;
        logic [ROW_W-1:0] key_row;
        logic             start_of_text;
    } t_in_item;

    typedef struct packed {
        logic [LET_W-1:0] out_letter;
        logic             letter_known;
        logic [ST_W-1:0]  status;
    } t_out_item;

    // One table entry: a set flag plus the mapped letter.
    typedef struct packed {
        logic             valid;
        logic [LET_W-1:0] letter;
    } t_entry;

    // Flat table address of a letter within a key row.
    function automatic logic [ADDR_W-1:0] f_addr(input logic [ROW_W-1:0] row,
                                                 input logic [LET_W-1:0] letter);
        return ADDR_W'(row) * ADDR_W'(LETTERS) + ADDR_W'(letter);
    endfunction

endpackage

/* rtl/periodic_substitution_key_table_top.sv */
// Periodic substitution key table.
// Input channel (i_in_valid / o_in_ready / i_in) carries one request per transfer:
// decode, substitute, undo in one row, undo in all rows, clear all, or reverse read.
// Output channel (o_out_valid / i_out_ready / o_out) returns exactly one result per
// request. The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes
// the period; it is always ready and should only be used while the block is idle.
// Substitute and error answers are given from the idle state; decode and reverse read
// wait in S_RD for the registered read of the two table memories; undo in one row
// clears that row and undo in all rows walks every row of the period in S_UW; clear
// all sweeps 26 * period entries via the single write port of each, one per cycle.
// After reset, and after every period write, a clearing pass writes all 832 entries
// of both tables, one per cycle, with o_in_ready low until the pass is done.
// The result register decouples the two sides: a new request is taken while an
// earlier result still waits. If the receiver stalls, the next finished result is
// parked in a holding register and the input side stops until it is delivered.
module periodic_substitution_key_table_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  pskt_pkg::t_in_item       i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output pskt_pkg::t_out_item      o_out,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [pskt_pkg::PER_W-1:0] i_cfg_data
);

`include "periodic_substitution_key_table_top_defines.svh"

    localparam logic [2:0] S_CLR  = 3'd0;  // clearing sweep over the tables
    localparam logic [2:0] S_IDLE = 3'd1;  // ready for a request
    localparam logic [2:0] S_RD   = 3'd2;  // table read data arrives
    localparam logic [2:0] S_UW   = 3'd3;  // undo walk, one row per cycle
    localparam logic [2:0] S_RESP = 3'd4;  // result parked, waiting for the receiver

    // Control state.
    logic [2:0]                    r_state, n_state;
    logic [pskt_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [pskt_pkg::ADDR_W-1:0]   r_last, n_last;
    logic                          r_clr_resp, n_clr_resp;
    logic [pskt_pkg::ROW_W-1:0]    r_row_cnt, n_row_cnt;
    logic [pskt_pkg::PER_W-1:0]    r_per, n_per;
    logic                          r_out_valid, n_out_valid;

    // Payload state.
    logic [pskt_pkg::ROW_W-1:0]    r_row, n_row;
    logic [pskt_pkg::LET_W-1:0]    r_ct, n_ct;
    logic                          r_single, n_single;
    logic                          r_sel, n_sel;
    pskt_pkg::t_out_item           r_res, n_res;
    pskt_pkg::t_out_item           r_out, n_out;

    // Table ports. The plain table maps cipher to plain, the cipher table the mirror.
    logic                          pl_we, ci_we;
    logic [pskt_pkg::ADDR_W-1:0]   pl_waddr, ci_waddr, pl_raddr, ci_raddr;
    pskt_pkg::t_entry              pl_wdata, ci_wdata, pl_rdata, ci_rdata, rd_entry;

    // Working signals.
    logic                          out_free;
    logic                          res_fire;
    pskt_pkg::t_out_item           res_val;
    logic [2:0]                    res_next;
    logic                          ct_ok, pt_ok, row_ok, walk_last;
    logic [pskt_pkg::ROW_W-1:0]    dec_row, rd_row;
    logic [pskt_pkg::PER_W-1:0]    dec_inc;

    pskt_ram #(
        .WIDTH ($bits(pskt_pkg::t_entry)),
        .DEPTH (pskt_pkg::DEPTH)
    ) u_plain_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    pskt_ram #(
        .WIDTH ($bits(pskt_pkg::t_entry)),
        .DEPTH (pskt_pkg::DEPTH)
    ) u_cipher_ram (
        .i_clk   (i_clk),
        .i_we    (ci_we),
        .i_waddr (ci_waddr),
        .i_wdata (ci_wdata),
        .i_raddr (ci_raddr),
        .o_rdata (ci_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign out_free = !r_out_valid || i_out_ready;
    assign ct_ok    = i_in.cipher_letter < pskt_pkg::LET_W'(pskt_pkg::LETTERS);
    assign pt_ok    = i_in.plain_letter < pskt_pkg::LET_W'(pskt_pkg::LETTERS);
    assign row_ok   = pskt_pkg::PER_W'(i_in.key_row) < r_per;

    // Decode row: restart on start of text, fold back if the counter is past the period.
    always_comb begin
        dec_row = i_in.start_of_text ? '0 : r_row_cnt;
        if (pskt_pkg::PER_W'(dec_row) >= r_per) begin
            dec_row = '0;
        end
        dec_inc = pskt_pkg::PER_W'(dec_row) + pskt_pkg::PER_W'(1);
    end

    always_comb begin
        if (i_in.req_type == pskt_pkg::REQ_UNDO_ALL) begin
            rd_row = '0;
        end else if (i_in.req_type == pskt_pkg::REQ_DECODE) begin
            rd_row = dec_row;
        end else begin
            rd_row = i_in.key_row;
        end
    end

    assign walk_last = r_single || (pskt_pkg::PER_W'(r_row) + pskt_pkg::PER_W'(1) >= r_per);
    assign rd_entry  = r_sel ? ci_rdata : pl_rdata;

    // Read addresses: the undo walk reads the next row while it clears the current one.
    assign pl_raddr = (r_state == S_UW)
                    ? pskt_pkg::f_addr(r_row + pskt_pkg::ROW_W'(1), r_ct)
                    : pskt_pkg::f_addr(rd_row, i_in.cipher_letter);
    assign ci_raddr = pskt_pkg::f_addr(i_in.key_row, i_in.plain_letter);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        n_clr_resp  = r_clr_resp;
        n_row_cnt   = r_row_cnt;
        n_per       = r_per;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_row       = r_row;
        n_ct        = r_ct;
        n_single    = r_single;
        n_sel       = r_sel;
        n_res       = r_res;

        res_fire = 1'b0;
        res_val  = '0;
        res_next = S_IDLE;

        pl_we    = 1'b0;
        pl_waddr = r_addr;
        pl_wdata = '0;
        ci_we    = 1'b0;
        ci_waddr = r_addr;
        ci_wdata = '0;

        unique case (r_state)
            S_CLR: begin
                pl_we = 1'b1;
                ci_we = 1'b1;
                if (r_addr == r_last) begin
                    if (r_clr_resp) begin
                        res_fire = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_addr = r_addr + pskt_pkg::ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.req_type > pskt_pkg::REQ_REVERSE) begin
                        res_fire = 1'b1;
                    end else if (r_per == '0) begin
                        res_fire       = 1'b1;
                        res_val.status = pskt_pkg::ST_NO_PERIOD;
                    end else begin
                        unique case (i_in.req_type)
                            pskt_pkg::REQ_DECODE: begin
                                n_row_cnt = (dec_inc >= r_per)
                                          ? '0 : pskt_pkg::ROW_W'(dec_inc);
                                if (ct_ok) begin
                                    n_sel   = 1'b0;
                                    n_state = S_RD;
                                end else begin
                                    res_fire = 1'b1;
                                end
                            end
                            pskt_pkg::REQ_UNDO_ALL: begin
                                if (ct_ok) begin
                                    n_row    = '0;
                                    n_ct     = i_in.cipher_letter;
                                    n_single = 1'b0;
                                    n_state  = S_UW;
                                end else begin
                                    res_fire = 1'b1;
                                end
                            end
                            pskt_pkg::REQ_CLEAR: begin
                                n_addr     = '0;
                                n_last     = pskt_pkg::ADDR_W'(r_per)
                                           * pskt_pkg::ADDR_W'(pskt_pkg::LETTERS)
                                           - pskt_pkg::ADDR_W'(1);
                                n_clr_resp = 1'b1;
                                n_state    = S_CLR;
                            end
                            default: begin
                                if (!row_ok) begin
                                    res_fire       = 1'b1;
                                    res_val.status = pskt_pkg::ST_BAD_ROW;
                                end else if (i_in.req_type == pskt_pkg::REQ_SUBST) begin
                                    // Both mirrored entries are written at once.
                                    res_fire = 1'b1;
                                    if (ct_ok && pt_ok) begin
                                        pl_we    = 1'b1;
                                        pl_waddr = pskt_pkg::f_addr(i_in.key_row,
                                                                    i_in.cipher_letter);
                                        pl_wdata = {1'b1, i_in.plain_letter};
                                        ci_we    = 1'b1;
                                        ci_waddr = pskt_pkg::f_addr(i_in.key_row,
                                                                    i_in.plain_letter);
                                        ci_wdata = {1'b1, i_in.cipher_letter};
                                    end
                                end else if (i_in.req_type == pskt_pkg::REQ_UNDO_ROW) begin
                                    if (ct_ok) begin
                                        n_row    = i_in.key_row;
                                        n_ct     = i_in.cipher_letter;
                                        n_single = 1'b1;
                                        n_state  = S_UW;
                                    end else begin
                                        res_fire = 1'b1;
                                    end
                                end else begin
                                    if (pt_ok) begin
                                        n_sel   = 1'b1;
                                        n_state = S_RD;
                                    end else begin
                                        res_fire = 1'b1;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                res_fire             = 1'b1;
                res_val.letter_known = rd_entry.valid;
                res_val.out_letter   = rd_entry.valid ? rd_entry.letter : '0;
            end
            S_UW: begin
                // Clear the forward entry and, if it was set, its mirror in this row.
                pl_we    = 1'b1;
                pl_waddr = pskt_pkg::f_addr(r_row, r_ct);
                if (pl_rdata.valid
                        && pl_rdata.letter < pskt_pkg::LET_W'(pskt_pkg::LETTERS)) begin
                    ci_we    = 1'b1;
                    ci_waddr = pskt_pkg::f_addr(r_row, pl_rdata.letter);
                end
                if (walk_last) begin
                    res_fire = 1'b1;
                end else begin
                    n_row = r_row + pskt_pkg::ROW_W'(1);
                end
            end
            S_RESP: begin
                res_fire = 1'b1;
                res_val  = r_res;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free.
        if (res_fire) begin
            if (out_free) begin
                n_out       = res_val;
                n_out_valid = 1'b1;
                n_state     = res_next;
            end else begin
                n_res   = res_val;
                n_state = S_RESP;
            end
        end

        // A period write empties both tables with a full sweep.
        if (i_cfg_valid) begin
            n_per      = (i_cfg_data > pskt_pkg::PER_W'(pskt_pkg::MAX_PERIOD))
                       ? pskt_pkg::PER_W'(pskt_pkg::MAX_PERIOD) : i_cfg_data;
            n_row_cnt  = '0;
            n_addr     = '0;
            n_last     = pskt_pkg::ADDR_W'(pskt_pkg::DEPTH - 1);
            n_clr_resp = 1'b0;
            n_state    = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_last      <= pskt_pkg::ADDR_W'(pskt_pkg::DEPTH - 1);
            r_clr_resp  <= 1'b0;
            r_row_cnt   <= '0;
            r_per       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_last      <= n_last;
            r_clr_resp  <= n_clr_resp;
            r_row_cnt   <= n_row_cnt;
            r_per       <= n_per;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_ct     <= n_ct;
        r_single <= n_single;
        r_sel    <= n_sel;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    `PSKT_CHECK_NEXT(a_cfg_blocks_input, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !o_in_ready, "input taken right after a period write")
    `PSKT_CHECK(a_row_cnt_range, i_clk, i_rst_n, r_per != '0, pskt_pkg::PER_W'(r_row_cnt) < r_per, "row counter not below period")
    `PSKT_CHECK(a_walk_row_range, i_clk, i_rst_n, r_state == S_UW, pskt_pkg::PER_W'(r_row) < r_per, "undo walk past period")
    `PSKT_CHECK(a_sweep_bound, i_clk, i_rst_n, r_state == S_CLR, r_addr <= r_last, "clearing sweep past its end")
    `PSKT_CHECK(a_error_blank, i_clk, i_rst_n, o_out_valid && (o_out.status != pskt_pkg::ST_OK), !o_out.letter_known && (o_out.out_letter == '0), "error result carries a letter")

endmodule

/* rtl/pskt_ram.sv */
module pskt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 832
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/pskt_answer_checker.sv */
`timescale 1ns / 100ps

// Watches the request, result and period channels of the key table, keeps its own copy
// of both substitution tables and the row counter, and compares every result transfer
// with the oldest outstanding prediction.
module pskt_answer_checker
    import pskt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [PER_W-1:0] i_cfg_data,
    output int               o_pending,
    output int               o_fail_count,
    output int               o_known_count
);

    t_entry           fwd_map  [DEPTH];
    t_entry           back_map [DEPTH];
    logic [ROW_W-1:0] row_ptr;
    logic [PER_W-1:0] period_reg;
    t_out_item        answer_q [$];
    int               mismatch_count = 0;
    int               known_count    = 0;

    // Period values above MAX_PERIOD behave as MAX_PERIOD, the number of table rows.
    function automatic int rows_in_use();
        return (period_reg > MAX_PERIOD) ? MAX_PERIOD : int'(period_reg);
    endfunction

    function automatic void wipe_tables();
        for (int k = 0; k < DEPTH; k++) begin
            fwd_map[k]  = '0;
            back_map[k] = '0;
        end
    endfunction

    // Clears one forward entry and the mirror entry it points at, if any.
    function automatic void drop_pair(input int row, input int ct);
        t_entry e;
        e = fwd_map[row * LETTERS + ct];
        fwd_map[row * LETTERS + ct] = '0;
        if (e.valid && e.letter < LETTERS)
            back_map[row * LETTERS + int'(e.letter)] = '0;
    endfunction

    function automatic t_out_item compute_answer(input t_in_item rq);
        t_out_item ans;
        t_entry    e;
        int        per;
        int        r;
        int        ct;
        int        pt;
        int        row;
        ans = '0;
        per = rows_in_use();
        ct  = int'(rq.cipher_letter);
        pt  = int'(rq.plain_letter);
        row = int'(rq.key_row);
        if (rq.req_type > REQ_REVERSE)
            return ans;
        if (per == 0) begin
            ans.status = ST_NO_PERIOD;
            return ans;
        end
        case (rq.req_type)
            REQ_DECODE: begin
                r = rq.start_of_text ? 0 : int'(row_ptr);
                if (r >= per)
                    r = 0;
                if (ct < LETTERS) begin
                    e = fwd_map[r * LETTERS + ct];
                    if (e.valid) begin
                        ans.letter_known = 1'b1;
                        ans.out_letter   = e.letter;
                    end
                end
                row_ptr = (r + 1 >= per) ? '0 : ROW_W'(r + 1);
            end
            REQ_UNDO_ALL: begin
                if (ct < LETTERS)
                    for (int j = 0; j < per; j++)
                        drop_pair(j, ct);
            end
            REQ_CLEAR: begin
                for (int j = 0; j < per * LETTERS; j++) begin
                    fwd_map[j]  = '0;
                    back_map[j] = '0;
                end
            end
            default: begin
                if (row >= per) begin
                    ans.status = ST_BAD_ROW;
                end else if (rq.req_type == REQ_SUBST) begin
                    if (ct < LETTERS && pt < LETTERS) begin
                        e.valid  = 1'b1;
                        e.letter = rq.cipher_letter;
                        back_map[row * LETTERS + pt] = e;
                        e.letter = rq.plain_letter;
                        fwd_map[row * LETTERS + ct] = e;
                    end
                end else if (rq.req_type == REQ_UNDO_ROW) begin
                    if (ct < LETTERS)
                        drop_pair(row, ct);
                end else if (pt < LETTERS) begin
                    e = back_map[row * LETTERS + pt];
                    if (e.valid) begin
                        ans.letter_known = 1'b1;
                        ans.out_letter   = e.letter;
                    end
                end
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t pskt_answer_checker: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            wipe_tables();
            row_ptr    = '0;
            period_reg = '0;
            answer_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                period_reg = i_cfg_data;
                wipe_tables();
                row_ptr = '0;
            end
            if (i_in_valid && i_in_ready)
                answer_q.push_back(compute_answer(i_in));
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result transfer with no request outstanding");
                end else begin
                    want = answer_q.pop_front();
                    check_field("out_letter", 8'(i_out.out_letter), 8'(want.out_letter));
                    check_field("letter_known", 8'(i_out.letter_known), 8'(want.letter_known));
                    check_field("status", 8'(i_out.status), 8'(want.status));
                    if (want.letter_known)
                        known_count++;
                end
            end
        end
        o_pending     <= answer_q.size();
        o_fail_count  <= mismatch_count;
        o_known_count <= known_count;
    end

endmodule

/* tb/tb_periodic_substitution_key_table_top.sv */
`timescale 1ns / 100ps

// Top of the key table testbench. It makes the clock, the reset and all stimulus and
// gives the verdict; prediction and comparison live in the checker beside the block.
module tb_periodic_substitution_key_table_top;

    import pskt_pkg::*;

    // Request codes that the block must answer with an all-zero result.
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    // A clear-all at the full period walks 832 entries, and every period write
    // starts a clearing pass over 832 entries, so the quiet limit sits well above both.
    localparam int WATCHDOG_LIMIT  = 6000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [PER_W-1:0] i_cfg_data;

    int pending;
    int fail_count;
    int known_count;

    // Idling percentages of the current phase, read by the sender and the receiver.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int sent_count     = 0;
    int cfg_count      = 0;
    int quiet_cycles   = 0;

    periodic_substitution_key_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    pskt_answer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out         (o_out),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count),
        .o_known_count (known_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver decides its ready anew every cycle. When the sender asks for a
    // hold-off, ready stays low for a fixed stretch counted here, so the result
    // register and the holding register fill and the input side has to stall.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Any transfer on any channel counts as progress. A hang shows up as a long run
    // of quiet cycles and ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_periodic_substitution_key_table_top: done, errors");
                $finish;
            end
        end
    end

    function automatic t_in_item make_request(input logic [REQ_W-1:0] req,
                                              input int ct, input int pt,
                                              input int row, input bit sot);
        t_in_item rq;
        rq.req_type      = req;
        rq.cipher_letter = LET_W'(ct);
        rq.plain_letter  = LET_W'(pt);
        rq.key_row       = ROW_W'(row);
        rq.start_of_text = sot;
        return rq;
    endfunction

    // Mostly well-formed traffic: letters in range, rows below the period, decodes and
    // substitutes dominating so the tables actually fill. A small share carries letters
    // past 'z', rows past the period, the expensive clears and the unused codes.
    function automatic t_in_item random_request(input int per);
        t_in_item rq;
        int       span;
        int       pick;
        span = (per == 0) ? 32 : ((per > MAX_PERIOD) ? MAX_PERIOD : per);
        rq.cipher_letter = ($urandom_range(19) == 0) ? LET_W'($urandom_range(31, 26))
                                                     : LET_W'($urandom_range(25));
        rq.plain_letter  = ($urandom_range(19) == 0) ? LET_W'($urandom_range(31, 26))
                                                     : LET_W'($urandom_range(25));
        rq.key_row       = ($urandom_range(9) == 0) ? ROW_W'($urandom_range(31))
                                                    : ROW_W'($urandom_range(span - 1));
        rq.start_of_text = ($urandom_range(15) == 0);
        pick = $urandom_range(99);
        if (pick < 36)
            rq.req_type = REQ_DECODE;
        else if (pick < 66)
            rq.req_type = REQ_SUBST;
        else if (pick < 78)
            rq.req_type = REQ_REVERSE;
        else if (pick < 87)
            rq.req_type = REQ_UNDO_ROW;
        else if (pick < 93)
            rq.req_type = REQ_UNDO_ALL;
        else if (pick < 95)
            rq.req_type = REQ_CLEAR;
        else
            rq.req_type = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        return rq;
    endfunction

    // Offers one request and returns at the edge of its transfer. Valid is only
    // lowered for a sender gap and never in the step that raises it again.
    task automatic send_request(input t_in_item rq);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= rq;
        do @(posedge i_clk); while (!o_in_ready);
        sent_count++;
    endtask

    // Stops offering and waits until every predicted result has been delivered.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PER_W-1:0] per);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= per;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_count++;
    endtask

    // One random phase at a fixed period and idling mix. With squeeze set, the
    // receiver is held off halfway through while requests keep coming, and a little
    // later the sender stops until every outstanding result has arrived.
    task automatic run_phase(input logic [PER_W-1:0] per, input int items,
                             input int spct, input int rpct, input bit squeeze);
        drain_results();
        write_period(per);
        send_idle_pct  = spct;
        recv_stall_pct = rpct;
        for (int n = 0; n < items; n++) begin
            if (squeeze && n == items / 2)
                hold_request = 1'b1;
            if (squeeze && n == items / 2 + 40)
                drain_results();
            send_request(random_request(int'(per)));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With no period set every real request answers "period not set", while
        // an unused code still answers all zeros.
        send_request(make_request(REQ_DECODE, 3, 0, 0, 1'b1));
        send_request(make_request(REQ_SUBST, 0, 25, 0, 1'b0));
        send_request(make_request(REQ_SPARE_HI, 31, 31, 31, 1'b1));
        drain_results();
        write_period(PER_W'(3));

        // Letter extremes in rows 0 and 2, then letters past 'z' that are ignored
        // and a row outside the period.
        send_request(make_request(REQ_SUBST, 0, 25, 0, 1'b0));
        send_request(make_request(REQ_SUBST, 25, 0, 2, 1'b0));
        send_request(make_request(REQ_SUBST, 31, 4, 0, 1'b0));
        send_request(make_request(REQ_SUBST, 4, 31, 1, 1'b0));
        send_request(make_request(REQ_SUBST, 1, 2, 31, 1'b0));
        // Decodes walk rows 0, 1, 2 and wrap to row 0; a letter past 'z' is not
        // known but still moves the row counter on.
        send_request(make_request(REQ_DECODE, 0, 0, 0, 1'b1));
        send_request(make_request(REQ_DECODE, 0, 0, 0, 1'b0));
        send_request(make_request(REQ_DECODE, 25, 0, 0, 1'b0));
        send_request(make_request(REQ_DECODE, 0, 0, 0, 1'b0));
        send_request(make_request(REQ_DECODE, 31, 0, 0, 1'b0));
        send_request(make_request(REQ_DECODE, 25, 0, 0, 1'b0));
        // Reverse reads: a hit, a letter past 'z', and a row outside the period.
        send_request(make_request(REQ_REVERSE, 0, 25, 0, 1'b0));
        send_request(make_request(REQ_REVERSE, 0, 26, 0, 1'b0));
        send_request(make_request(REQ_REVERSE, 0, 0, 3, 1'b0));
        // Remapping a cipher letter leaves the old mirror entry in place, and
        // undoing the new mapping does not remove that stale entry either.
        send_request(make_request(REQ_SUBST, 0, 7, 0, 1'b0));
        send_request(make_request(REQ_REVERSE, 0, 25, 0, 1'b0));
        send_request(make_request(REQ_UNDO_ROW, 0, 0, 0, 1'b0));
        send_request(make_request(REQ_REVERSE, 0, 25, 0, 1'b0));
        send_request(make_request(REQ_UNDO_ROW, 0, 0, 5, 1'b0));
        send_request(make_request(REQ_UNDO_ALL, 25, 0, 0, 1'b0));
        send_request(make_request(REQ_DECODE, 25, 0, 0, 1'b0));
        send_request(make_request(REQ_SUBST, 3, 3, 1, 1'b0));
        send_request(make_request(REQ_CLEAR, 0, 0, 0, 1'b0));
        send_request(make_request(REQ_DECODE, 3, 0, 0, 1'b0));
        send_request(make_request(REQ_SPARE_LO, 0, 0, 0, 1'b0));

        // Random phases over the period extremes (1, 32, 63 which saturates, 0)
        // and a few ordinary values, cycling through the idling mixes.
        run_phase(PER_W'(1), 150, 0, 0, 1'b0);
        run_phase(PER_W'(32), 250, 63, 0, 1'b0);
        run_phase(PER_W'(63), 200, 0, 63, 1'b0);
        run_phase(PER_W'(5), 250, 8, 8, 1'b0);
        run_phase(PER_W'(13), 250, 0, 0, 1'b1);
        run_phase(PER_W'(0), 40, 8, 8, 1'b0);
        run_phase(PER_W'(20), 200, 63, 0, 1'b0);
        run_phase(PER_W'(2), 150, 0, 63, 1'b0);
        run_phase(PER_W'(9), 200, 8, 8, 1'b0);

        drain_results();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d requests under %0d period settings; %0d answers came from",
                 sent_count, cfg_count, known_count);
        $display("filled table entries, with stalls and gaps on both sides.");
        if (fail_count == 0 && pending == 0)
            $display("tb_periodic_substitution_key_table_top: done, clean");
        else
            $display("tb_periodic_substitution_key_table_top: done, errors");
        $finish;
    end

endmodule
